// ----- hdl/cbz_pkg.sv -----
package cbz_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int OUT_BITS        = 16;
    localparam int OUT_FRAC_BITS   = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int NUM_REGS        = 8;
    localparam int NUM_CTRL_PTS    = 4;
    localparam int PIPE_DEPTH      = 4;

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_PULL1_X = 3'd2;
    localparam logic [2:0] REG_PULL1_Y = 3'd3;
    localparam logic [2:0] REG_PULL2_X = 3'd4;
    localparam logic [2:0] REG_PULL2_Y = 3'd5;
    localparam logic [2:0] REG_END_X   = 3'd6;
    localparam logic [2:0] REG_END_Y   = 3'd7;

    localparam logic [15:0] REG_RESET [NUM_REGS] = '{
        16'd483, 16'd310, 16'd430, 16'd295, 16'd420, 16'd220, 16'd486, 16'd212
    };

    localparam logic [1:0] BERN_COEF [NUM_CTRL_PTS] = '{2'd1, 2'd3, 2'd3, 2'd1};

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;
        logic [PIPE_DEPTH-1:0] valid;
    } t_pipe_ctl;

endpackage

// ----- hdl/cbz_blend.sv -----
module cbz_blend #(
    parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  cbz_pkg::t_pipe_ctl                        i_ctl,
    input  logic [T_FRAC_BITS-1:0]                    i_t,
    output logic [cbz_pkg::NUM_CTRL_PTS-1:0][3*T_FRAC_BITS:0] o_blend
);

    localparam int TW  = T_FRAC_BITS;
    localparam int SW  = TW + 1;
    localparam int BW  = 3 * TW + 1;
    localparam int CHK = 3 * TW + 3;

    logic [SW-1:0]      w_s;
    logic [TW-1:0]      r_t;
    logic [SW-1:0]      r_s;
    logic [2*TW-1:0]    r_t2;
    logic [2*SW-1:0]    r_s2;
    logic [TW+SW-1:0]   r_ts;
    logic [cbz_pkg::NUM_CTRL_PTS-1:0][BW-1:0] r_blend;
    logic [cbz_pkg::NUM_CTRL_PTS-1:0][BW-1:0] n_blend;

    assign w_s = {1'b1, {TW{1'b0}}} - SW'(i_t);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_t  <= i_t;
            r_s  <= w_s;
            r_t2 <= (2*TW)'(i_t) * (2*TW)'(i_t);
            r_s2 <= (2*SW)'(w_s) * (2*SW)'(w_s);
            r_ts <= (TW+SW)'(i_t) * (TW+SW)'(w_s);
        end
    end

    always_comb begin
        n_blend[0] = BW'(r_s2) * BW'(r_s);
        n_blend[1] = BW'(r_ts) * BW'(r_s);
        n_blend[2] = BW'(r_t2) * BW'(r_s);
        n_blend[3] = BW'(r_t2) * BW'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_blend <= n_blend;
        end
    end

    assign o_blend = r_blend;

`ifndef ASSERT_OFF
    a_blend_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid[1] |-> (CHK'(r_blend[0]) + CHK'(3) * CHK'(r_blend[1])
            + CHK'(3) * CHK'(r_blend[2]) + CHK'(r_blend[3])) == (CHK'(1) << (3*TW)))
        else $error("Bernstein blends do not sum to one.");
`endif

endmodule

// ----- hdl/cbz_axis.sv -----
module cbz_axis #(
    parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  cbz_pkg::t_pipe_ctl                                i_ctl,
    input  logic [cbz_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0]  i_coord,
    input  logic [cbz_pkg::NUM_CTRL_PTS-1:0][3*T_FRAC_BITS:0] i_blend,
    output logic [cbz_pkg::OUT_BITS-1:0]                      o_point
);

    localparam int TW   = T_FRAC_BITS;
    localparam int CW   = COORD_BITS;
    localparam int BW   = 3 * TW + 1;
    localparam int PW   = BW + CW + 2;
    localparam int SUMW = 3 * TW + CW + 8;
    localparam int RPOS = 3 * TW - cbz_pkg::OUT_FRAC_BITS - 1;

    logic [cbz_pkg::NUM_CTRL_PTS-1:0][PW-1:0] r_prod;
    logic [cbz_pkg::NUM_CTRL_PTS-1:0][PW-1:0] n_prod;
    logic [SUMW-1:0]                          w_sum;
    logic [cbz_pkg::OUT_BITS-1:0]             r_point;

    always_comb begin
        for (int k = 0; k < cbz_pkg::NUM_CTRL_PTS; k++) begin
            n_prod[k] = PW'(i_blend[k])
                * (PW'(i_coord[k]) * PW'(cbz_pkg::BERN_COEF[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_prod <= n_prod;
        end
    end

    assign w_sum = SUMW'(r_prod[0]) + SUMW'(r_prod[1]) + SUMW'(r_prod[2])
                 + SUMW'(r_prod[3]) + (SUMW'(1) << RPOS);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_point <= w_sum[RPOS+1 +: cbz_pkg::OUT_BITS];
        end
    end

    assign o_point = r_point;

endmodule

// ----- hdl/cubic_bezier_point_eval_core.sv -----
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid / tready         tdata: curve_t
// m_axis    out        tvalid / tready         tdata: point_x, point_y
// cfg       in         valid / ready           index: register, data: coordinate
//
// Output valid comes from the last stage register; one point per cycle while m_axis is not
// stalled. The four stages are t powers, Bernstein blends, coordinate products, and sum
// with rounding. Reset clears the pipeline valid bits and loads the default control points.
// Each stage holds while the stage after it is full and stalled, so a bubble is filled.
// The configuration channel is always ready; the user must write it only while the
// pipeline is empty, which the block does not enforce.
module cubic_bezier_point_eval_core #(
    parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Bits from lowest: curve_t, zero fill to whole bytes.
    input  logic [((T_FRAC_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // Bits from lowest: point_x, point_y.
    output logic [2*cbz_pkg::OUT_BITS-1:0]        o_m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [COORD_BITS-1:0]                 i_cfg_data
);

    localparam int BW = 3 * T_FRAC_BITS + 1;

    logic [COORD_BITS-1:0]                        r_coord [cbz_pkg::NUM_REGS];
    logic [cbz_pkg::PIPE_DEPTH-1:0]               r_valid;
    cbz_pkg::t_pipe_ctl                           w_ctl;
    logic [cbz_pkg::NUM_CTRL_PTS-1:0][BW-1:0]     w_blend;
    logic [cbz_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0] w_coord_x;
    logic [cbz_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0] w_coord_y;
    logic [cbz_pkg::OUT_BITS-1:0]                 w_point_x;
    logic [cbz_pkg::OUT_BITS-1:0]                 w_point_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbz_pkg::NUM_REGS; i++) begin
                r_coord[i] <= COORD_BITS'(cbz_pkg::REG_RESET[i]);
            end
        end else if (i_cfg_valid && !i_cfg_index[cbz_pkg::CFG_IDX_W-1]) begin
            r_coord[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        w_ctl.valid = r_valid;
        w_ctl.en[3] = !r_valid[3] || i_m_axis_tready;
        for (int k = cbz_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_valid[k] || w_ctl.en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ctl.en[0]) begin
                r_valid[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < cbz_pkg::PIPE_DEPTH; k++) begin
                if (w_ctl.en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_ctl.en[0];
    assign o_m_axis_tvalid = r_valid[3];

    assign w_coord_x = {r_coord[cbz_pkg::REG_END_X],   r_coord[cbz_pkg::REG_PULL2_X],
                        r_coord[cbz_pkg::REG_PULL1_X], r_coord[cbz_pkg::REG_START_X]};
    assign w_coord_y = {r_coord[cbz_pkg::REG_END_Y],   r_coord[cbz_pkg::REG_PULL2_Y],
                        r_coord[cbz_pkg::REG_PULL1_Y], r_coord[cbz_pkg::REG_START_Y]};

    cbz_blend #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_t     (i_s_axis_tdata[T_FRAC_BITS-1:0]),
        .o_blend (w_blend)
    );

    cbz_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_coord (w_coord_x),
        .i_blend (w_blend),
        .o_point (w_point_x)
    );

    cbz_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_coord (w_coord_y),
        .i_blend (w_blend),
        .o_point (w_point_y)
    );

    assign o_m_axis_tdata = {w_point_y, w_point_x};

`ifndef ASSERT_OFF
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ctl.en[3] |-> r_valid[3])
        else $error("Output stage stalled while empty.");

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_valid == '1))
        else $error("Input refused while a pipeline stage is empty.");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_valid[0])
        else $error("Accepted transaction did not enter the first stage.");

    a_held_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[2] && !w_ctl.en[2]) |=> r_valid[2])
        else $error("Stalled product stage lost its item.");
`endif

endmodule

// ----- bench/bezier_point_checker.sv -----
module bezier_point_checker (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_t_valid,
    input  logic                                                i_t_ready,
    input  logic [((cbz_pkg::T_FRAC_BITS_DEF+7)/8)*8-1:0]       i_t_data,
    input  logic                                                i_pt_valid,
    input  logic                                                i_pt_ready,
    input  logic [2*cbz_pkg::OUT_BITS-1:0]                      i_pt_data,
    input  logic                                                i_cfg_valid,
    input  logic                                                i_cfg_ready,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]                       i_cfg_index,
    input  logic [cbz_pkg::COORD_BITS_DEF-1:0]                  i_cfg_data,
    output int                                                  o_fail_count,
    output int                                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int T_W         = cbz_pkg::T_FRAC_BITS_DEF;
    localparam int C_W         = cbz_pkg::COORD_BITS_DEF;
    localparam int O_W         = cbz_pkg::OUT_BITS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [O_W-1:0] y;
        logic [O_W-1:0] x;
    } t_point;

    logic [C_W-1:0] ctrl_pts [cbz_pkg::NUM_REGS];
    t_point         expected_points [$];
    int             mismatches = 0;

    // The weighted sum keeps all 3*T_W fraction bits before rounding to Q.4.
    function automatic logic [O_W-1:0] blend_axis(input logic [T_W-1:0] t,
                                                  input logic [C_W-1:0] p0,
                                                  input logic [C_W-1:0] p1,
                                                  input logic [C_W-1:0] p2,
                                                  input logic [C_W-1:0] p3);
        logic [79:0] tw;
        logic [79:0] sw;
        logic [79:0] acc;
        tw  = 80'(t);
        sw  = (80'd1 << T_W) - tw;
        acc = 80'(p0) * sw * sw * sw
            + 80'd3 * 80'(p1) * tw * sw * sw
            + 80'd3 * 80'(p2) * tw * tw * sw
            + 80'(p3) * tw * tw * tw;
        acc = acc + (80'd1 << (3*T_W - 5));
        return O_W'(acc >> (3*T_W - 4));
    endfunction

    function automatic t_point bezier_point(input logic [T_W-1:0] t);
        t_point p;
        p.x = blend_axis(t, ctrl_pts[cbz_pkg::REG_START_X], ctrl_pts[cbz_pkg::REG_PULL1_X],
                         ctrl_pts[cbz_pkg::REG_PULL2_X], ctrl_pts[cbz_pkg::REG_END_X]);
        p.y = blend_axis(t, ctrl_pts[cbz_pkg::REG_START_Y], ctrl_pts[cbz_pkg::REG_PULL1_Y],
                         ctrl_pts[cbz_pkg::REG_PULL2_Y], ctrl_pts[cbz_pkg::REG_END_Y]);
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            for (int i = 0; i < cbz_pkg::NUM_REGS; i++) begin
                ctrl_pts[i] = cbz_pkg::REG_RESET[i][C_W-1:0];
            end
            expected_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < cbz_pkg::NUM_REGS) begin
                ctrl_pts[i_cfg_index[2:0]] = i_cfg_data;
            end
            if (i_pt_valid && i_pt_ready) begin
                got = i_pt_data;
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected point x=%0d y=%0d with nothing pending",
                                 got.x, got.y);
                    end
                end else begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     want.x, want.y, got.x, got.y);
                        end
                    end
                end
            end
            if (i_t_valid && i_t_ready) begin
                expected_points.push_back(bezier_point(i_t_data[T_W-1:0]));
            end
        end
        o_pending    <= expected_points.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int T_W       = cbz_pkg::T_FRAC_BITS_DEF;
    localparam int C_W       = cbz_pkg::COORD_BITS_DEF;
    localparam int I_W       = cbz_pkg::CFG_IDX_W;
    localparam int D_W       = ((T_W+7)/8)*8;
    localparam int T_MAX     = (1 << T_W) - 1;
    localparam int C_MAX     = (1 << C_W) - 1;
    localparam int PHASES    = 10;
    localparam int PER_PHASE = 103;
    localparam int LONG_HOLD = 80;
    localparam int DRAIN     = 4 * cbz_pkg::PIPE_DEPTH;
    localparam int LIMIT_NS  = 5_000_000;
    localparam int CALM_PH   = 3;
    localparam int HOLD_PH   = 6;

    localparam logic [C_W-1:0] CMAX = C_W'(C_MAX);
    localparam logic [C_W-1:0] CMIN = '0;

    localparam logic [T_W-1:0] EDGE_T [9] = '{
        16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'h7FFF,
        16'h4000, 16'hC000, 16'h5555, 16'hAAAA
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [D_W-1:0]                i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [2*cbz_pkg::OUT_BITS-1:0] o_m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [I_W-1:0]                i_cfg_index = '0;
    logic [C_W-1:0]                i_cfg_data = '0;

    int fail_count;
    int pending;
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;
    int long_hold_asks = 0;
    int long_hold_served = 0;

    cubic_bezier_point_eval_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    bezier_point_checker point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_t_valid    (i_s_axis_tvalid),
        .i_t_ready    (o_s_axis_tready),
        .i_t_data     (i_s_axis_tdata),
        .i_pt_valid   (o_m_axis_tvalid),
        .i_pt_ready   (i_m_axis_tready),
        .i_pt_data    (o_m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #LIMIT_NS;
        $display("status: fail");
        $finish;
    end

    // Output side: short random stalls, a few long ones, a long hold on request, and no stalls while calm.
    initial begin
        int hold_left;
        int r;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_asks != long_hold_served) begin
                long_hold_served = long_hold_asks;
                hold_left = LONG_HOLD;
            end
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (take_calm || r < 70) begin
                i_m_axis_tready <= 1'b1;
            end else if (r < 96) begin
                hold_left = $urandom_range(0, 3);
                i_m_axis_tready <= 1'b0;
            end else begin
                hold_left = $urandom_range(10, 40);
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [T_W-1:0] random_t();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return T_W'($urandom_range(0, 15));
        if (r == 1) return T_W'(T_MAX - $urandom_range(0, 15));
        return T_W'($urandom_range(0, T_MAX));
    endfunction

    task automatic send_t(input logic [T_W-1:0] t);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= D_W'(t);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_points();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [I_W-1:0] idx, input logic [C_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // A write to an index past the last register must leave every point unchanged.
    task automatic load_points(input logic [C_W-1:0] x0, input logic [C_W-1:0] y0,
                               input logic [C_W-1:0] x1, input logic [C_W-1:0] y1,
                               input logic [C_W-1:0] x2, input logic [C_W-1:0] y2,
                               input logic [C_W-1:0] x3, input logic [C_W-1:0] y3);
        write_reg(I_W'(cbz_pkg::REG_START_X), x0);
        write_reg(I_W'(cbz_pkg::REG_START_Y), y0);
        write_reg(I_W'(cbz_pkg::REG_PULL1_X), x1);
        write_reg(I_W'(cbz_pkg::REG_PULL1_Y), y1);
        write_reg(I_W'(cbz_pkg::REG_PULL2_X), x2);
        write_reg(I_W'(cbz_pkg::REG_PULL2_Y), y2);
        write_reg(I_W'(cbz_pkg::REG_END_X), x3);
        write_reg(I_W'(cbz_pkg::REG_END_Y), y3);
        write_reg(I_W'(cbz_pkg::NUM_REGS + $urandom_range(0, cbz_pkg::NUM_REGS - 1)),
                  C_W'($urandom_range(0, C_MAX)));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [C_W-1:0] random_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return CMAX;
        return C_W'($urandom_range(0, C_MAX));
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 9; i++) send_t(EDGE_T[i]);
        drain_points();

        load_points(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_t(EDGE_T[0]);
        send_t(EDGE_T[2]);
        send_t(EDGE_T[3]);
        drain_points();

        load_points(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_t(16'h1234);
        send_t(EDGE_T[3]);
        drain_points();

        load_points(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX);
        send_t(EDGE_T[0]);
        send_t(EDGE_T[2]);
        send_t(EDGE_T[3]);
        send_t(16'h2AAA);
        drain_points();

        load_points(CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_t(EDGE_T[5]);
        send_t(EDGE_T[6]);
        drain_points();

        for (int ph = 0; ph < PHASES; ph++) begin
            load_points(random_coord(), random_coord(), random_coord(), random_coord(),
                        random_coord(), random_coord(), random_coord(), random_coord());
            send_calm = (ph == CALM_PH || ph == HOLD_PH);
            take_calm = (ph == CALM_PH);
            if (ph == HOLD_PH) long_hold_asks++;
            for (int n = 0; n < PER_PHASE; n++) send_t(random_t());
            drain_points();
        end

        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- cubic_bezier_point_eval_core.f -----
hdl/cbz_pkg.sv
hdl/cbz_blend.sv
hdl/cbz_axis.sv
hdl/cubic_bezier_point_eval_core.sv
bench/bezier_point_checker.sv
bench/tb.sv
